// ===== rtl/root_locus_rule_engine_core_defines.svh =====
// assertion macros for the root locus rule engine
`ifndef ROOT_LOCUS_RULE_ENGINE_CORE_DEFINES_SVH
`define ROOT_LOCUS_RULE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define RLRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rlre_pkg.sv =====
// shared constants and tables for the root locus rule engine
`timescale 1ns / 1ps
package rlre_pkg;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_ADD_POLE = 3'd1;
  localparam logic [2:0] OP_ADD_ZERO = 3'd2;
  localparam logic [2:0] OP_DEPART = 3'd3;
  localparam logic [2:0] OP_ARRIVE = 3'd4;
  localparam logic [2:0] OP_REAL_AXIS = 3'd5;
  localparam logic [2:0] OP_CENTROID = 3'd6;
  localparam logic [2:0] OP_ASYMPTOTE = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NO_ASYM = 2'd3;

  localparam int ZW = 34;
  localparam int AW = 40;
  localparam int DVW = 40;
  localparam int MAX_RUN = 16;

  localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic [33:0] PI_Q32 = 34'd13493037705;
  localparam logic signed [63:0] NORM_COARSE = 64'sd562949953421312;
  localparam logic signed [63:0] NORM_FINE = 64'sd144115188075855872;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0: r = 32'h3243F6A8;
      5'd1: r = 32'h1DAC6705;
      5'd2: r = 32'h0FADBAFC;
      5'd3: r = 32'h07F56EA6;
      5'd4: r = 32'h03FEAB76;
      5'd5: r = 32'h01FFD55B;
      5'd6: r = 32'h00FFFAAA;
      5'd7: r = 32'h007FFF55;
      5'd8: r = 32'h003FFFEA;
      5'd9: r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/root_locus_rule_engine_core.sv =====
// root locus rule engine: pole/zero tables, cordic angle sums, real-axis test, centroid and asymptotes
// clear and add: result registered in the cycle after the transfer, one item in flight until the result is taken
// departure/arrival: reference fetch, then per element a fetch, normalise shifts and cordic rotations
// real-axis test and centroid: a fetch and an element step per stored element, centroid then runs the divider
// asymptotes: a divider run per angle, up to 16 angles; cordic and divider set the pace
// reset clears counts and control; tables are undefined until written
`timescale 1ns / 1ps
`include "root_locus_rule_engine_core_defines.svh"
module root_locus_rule_engine_core #(
  parameter int MAX_ORDER = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // index[3:0], re_part[35:4], im_part[67:36]
  input  logic [2:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // value
  output logic [2:0]  out_tuser,  // on_locus[0], status[2:1]
  output logic        out_tlast
);

  localparam int CW = $clog2(MAX_ORDER + 1);
  localparam int IW = $clog2(MAX_ORDER);
  localparam int KW = CW + 4;
  localparam int SW = $clog2(CORDIC_STEPS);
  localparam int DENW = CW + 16;

  typedef enum logic [3:0] {
    S_IDLE, S_REF, S_FETCH, S_ELEM, S_NORM, S_ROT, S_ASYM, S_DIV, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [63:0] pole_mem [MAX_ORDER];
  logic [63:0] zero_mem [MAX_ORDER];
  logic [63:0] pole_rd_r, zero_rd_r;
  logic [IW-1:0] rd_addr;
  logic pole_we, zero_we;

  logic [CW-1:0] pole_cnt_r, pole_cnt_nxt, zero_cnt_r, zero_cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic ph_r, ph_nxt;
  logic [2:0] op_r, op_nxt;
  logic [3:0] k_r, k_nxt;
  logic signed [31:0] x_r, x_nxt, ref_re_r, ref_re_nxt, ref_im_r, ref_im_nxt;
  logic signed [63:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [rlre_pkg::ZW-1:0] z_r, z_nxt;
  logic signed [rlre_pkg::AW-1:0] ang_r, ang_nxt;
  logic sub_r, sub_nxt;
  logic [SW-1:0] st_r, st_nxt;
  logic parity_r, parity_nxt;
  logic neg_r, neg_nxt;
  logic [3:0] j_r, j_nxt;
  logic [rlre_pkg::DVW-1:0] dq_r, dq_nxt;
  logic [rlre_pkg::DVW-1:0] num_r, num_nxt;
  logic [DENW-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [5:0] dcnt_r, dcnt_nxt;
  logic out_valid_r, out_valid_nxt, out_on_r, out_on_nxt, out_last_r, out_last_nxt;
  logic [47:0] out_value_r, out_value_nxt;
  logic [1:0] out_status_r, out_status_nxt;

  logic [3:0] in_k;
  logic signed [31:0] in_re, in_im;
  logic use_pole;
  logic [CW-1:0] len, na;
  logic [63:0] elem;
  logic signed [31:0] e_re, e_im;
  logic signed [32:0] dx, dy;
  logic signed [63:0] ay, mag, sx, sy;
  logic signed [rlre_pkg::AW-1:0] rnd;
  logic [rlre_pkg::AW-1:0] acc_mag;
  logic [DENW:0] trial;
  logic [rlre_pkg::DVW-1:0] dq_shift;
  logic [47:0] qv;

  assign in_k = in_tdata[3:0];
  assign in_re = in_tdata[35:4];
  assign in_im = in_tdata[67:36];
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_value_r;
  assign out_tuser = {out_status_r, out_on_r};
  assign out_tlast = out_last_r;

  assign rd_addr = (state_r == S_IDLE) ? IW'(in_k) : i_r[IW-1:0];
  assign pole_we = in_tvalid && in_tready && (in_tuser == rlre_pkg::OP_ADD_POLE)
                   && (pole_cnt_r < CW'(MAX_ORDER));
  assign zero_we = in_tvalid && in_tready && (in_tuser == rlre_pkg::OP_ADD_ZERO)
                   && (zero_cnt_r < CW'(MAX_ORDER));

  always_ff @(posedge clk) begin
    if (pole_we) pole_mem[pole_cnt_r[IW-1:0]] <= {in_re, in_im};
    if (zero_we) zero_mem[zero_cnt_r[IW-1:0]] <= {in_re, in_im};
    pole_rd_r <= pole_mem[rd_addr];
    zero_rd_r <= zero_mem[rd_addr];
  end

  always_comb begin
    use_pole = (op_r == rlre_pkg::OP_DEPART) ? ph_r : !ph_r;
    len = use_pole ? pole_cnt_r : zero_cnt_r;
    na = pole_cnt_r - zero_cnt_r;
    elem = use_pole ? pole_rd_r : zero_rd_r;
    e_re = elem[63:32];
    e_im = elem[31:0];
    dx = 33'(ref_re_r) - 33'(e_re);
    dy = 33'(ref_im_r) - 33'(e_im);
    ay = (cy_r < 0) ? -cy_r : cy_r;
    mag = (cx_r > ay) ? cx_r : ay;
    sx = cx_r >>> st_r;
    sy = cy_r >>> st_r;
    if (ang_r >= 0) rnd = (ang_r + 40'sd8192) >>> 14;
    else rnd = -(((-ang_r) + 40'sd8192) >>> 14);
    acc_mag = (ang_r < 0) ? rlre_pkg::AW'(-ang_r) : rlre_pkg::AW'(ang_r);
    trial = {rem_r, dq_r[rlre_pkg::DVW-1]};
    dq_shift = {dq_r[rlre_pkg::DVW-2:0], 1'b0};
    qv = {8'd0, dq_r};
  end

  always_comb begin
    state_nxt = state_r;
    pole_cnt_nxt = pole_cnt_r;
    zero_cnt_nxt = zero_cnt_r;
    i_nxt = i_r;
    ph_nxt = ph_r;
    op_nxt = op_r;
    k_nxt = k_r;
    x_nxt = x_r;
    ref_re_nxt = ref_re_r;
    ref_im_nxt = ref_im_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    z_nxt = z_r;
    ang_nxt = ang_r;
    sub_nxt = sub_r;
    st_nxt = st_r;
    parity_nxt = parity_r;
    neg_nxt = neg_r;
    j_nxt = j_r;
    dq_nxt = dq_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    dcnt_nxt = dcnt_r;
    out_valid_nxt = out_valid_r;
    out_on_nxt = out_on_r;
    out_last_nxt = out_last_r;
    out_value_nxt = out_value_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_tuser;
          k_nxt = in_k;
          x_nxt = in_re;
          i_nxt = '0;
          ph_nxt = 1'b0;
          parity_nxt = 1'b0;
          ang_nxt = rlre_pkg::AW'(rlre_pkg::PI_Q30);
          j_nxt = '0;
          num_nxt = rlre_pkg::DVW'(rlre_pkg::PI_Q32);
          out_value_nxt = '0;
          out_on_nxt = 1'b0;
          out_last_nxt = 1'b1;
          out_status_nxt = rlre_pkg::ST_OK;
          unique case (in_tuser)
            rlre_pkg::OP_CLEAR: begin
              pole_cnt_nxt = '0;
              zero_cnt_nxt = '0;
              out_valid_nxt = 1'b1;
              state_nxt = S_OUT;
            end
            rlre_pkg::OP_ADD_POLE: begin
              if (pole_we) pole_cnt_nxt = pole_cnt_r + 1'b1;
              else out_status_nxt = rlre_pkg::ST_FULL;
              out_valid_nxt = 1'b1;
              state_nxt = S_OUT;
            end
            rlre_pkg::OP_ADD_ZERO: begin
              if (zero_we) zero_cnt_nxt = zero_cnt_r + 1'b1;
              else out_status_nxt = rlre_pkg::ST_FULL;
              out_valid_nxt = 1'b1;
              state_nxt = S_OUT;
            end
            rlre_pkg::OP_DEPART, rlre_pkg::OP_ARRIVE: begin
              if (KW'(in_k) >= KW'((in_tuser == rlre_pkg::OP_DEPART) ? pole_cnt_r
                                                                    : zero_cnt_r)) begin
                out_status_nxt = rlre_pkg::ST_BAD_INDEX;
                out_valid_nxt = 1'b1;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_REF;
              end
            end
            rlre_pkg::OP_REAL_AXIS: state_nxt = S_FETCH;
            rlre_pkg::OP_CENTROID, rlre_pkg::OP_ASYMPTOTE: begin
              ang_nxt = '0;
              if (pole_cnt_r <= zero_cnt_r) begin
                out_status_nxt = rlre_pkg::ST_NO_ASYM;
                out_valid_nxt = 1'b1;
                state_nxt = S_OUT;
              end else if (in_tuser == rlre_pkg::OP_CENTROID) begin
                state_nxt = S_FETCH;
              end else begin
                state_nxt = S_ASYM;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_REF: begin
        if (op_r == rlre_pkg::OP_DEPART) begin
          ref_re_nxt = pole_rd_r[63:32];
          ref_im_nxt = pole_rd_r[31:0];
        end else begin
          ref_re_nxt = zero_rd_r[63:32];
          ref_im_nxt = zero_rd_r[31:0];
        end
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        if (i_r == len) begin
          i_nxt = '0;
          if (!ph_r) begin
            ph_nxt = 1'b1;
          end else if (op_r == rlre_pkg::OP_REAL_AXIS) begin
            out_on_nxt = parity_r;
            out_valid_nxt = 1'b1;
            state_nxt = S_OUT;
          end else if (op_r == rlre_pkg::OP_CENTROID) begin
            neg_nxt = ang_r < 0;
            den_nxt = DENW'(na);
            dq_nxt = acc_mag + rlre_pkg::DVW'(na >> 1);
            rem_nxt = '0;
            dcnt_nxt = '0;
            state_nxt = S_DIV;
          end else begin
            out_value_nxt = 48'(rnd);
            out_valid_nxt = 1'b1;
            state_nxt = S_OUT;
          end
        end else if (ph_r && (op_r == rlre_pkg::OP_DEPART || op_r == rlre_pkg::OP_ARRIVE)
                     && (KW'(i_r) == KW'(k_r))) begin
          i_nxt = i_r + 1'b1;
        end else begin
          state_nxt = S_ELEM;
        end
      end
      S_ELEM: begin
        i_nxt = i_r + 1'b1;
        state_nxt = S_FETCH;
        if (op_r == rlre_pkg::OP_REAL_AXIS) begin
          if (e_im == 0 && e_re > x_r) parity_nxt = !parity_r;
        end else if (op_r == rlre_pkg::OP_CENTROID) begin
          if (use_pole) ang_nxt = ang_r + rlre_pkg::AW'(e_re);
          else ang_nxt = ang_r - rlre_pkg::AW'(e_re);
        end else if (dx != 0 || dy != 0) begin
          sub_nxt = !use_pole;
          if (dx < 0) begin
            z_nxt = (dy >= 0) ? rlre_pkg::PI_Q30 : -rlre_pkg::PI_Q30;
            cx_nxt = -64'(dx);
            cy_nxt = -64'(dy);
          end else begin
            z_nxt = '0;
            cx_nxt = 64'(dx);
            cy_nxt = 64'(dy);
          end
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        st_nxt = '0;
        if (mag < rlre_pkg::NORM_COARSE) begin
          cx_nxt = cx_r <<< 8;
          cy_nxt = cy_r <<< 8;
        end else if (mag < rlre_pkg::NORM_FINE) begin
          cx_nxt = cx_r <<< 1;
          cy_nxt = cy_r <<< 1;
        end else begin
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        if (cy_r < 0) begin
          cx_nxt = cx_r - sy;
          cy_nxt = cy_r + sx;
          z_nxt = z_r - rlre_pkg::ZW'(rlre_pkg::atan_q30(5'(st_r)));
        end else begin
          cx_nxt = cx_r + sy;
          cy_nxt = cy_r - sx;
          z_nxt = z_r + rlre_pkg::ZW'(rlre_pkg::atan_q30(5'(st_r)));
        end
        st_nxt = st_r + 1'b1;
        if (st_r == SW'(CORDIC_STEPS - 1)) begin
          if (sub_r) ang_nxt = ang_r - rlre_pkg::AW'(z_nxt);
          else ang_nxt = ang_r + rlre_pkg::AW'(z_nxt);
          state_nxt = S_FETCH;
        end
      end
      S_ASYM: begin
        neg_nxt = 1'b0;
        den_nxt = {DENW'(na)} << 16;
        dq_nxt = num_r + rlre_pkg::DVW'(({DENW'(na)} << 16) >> 1);
        rem_nxt = '0;
        dcnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dcnt_r == 6'(rlre_pkg::DVW)) begin
          out_value_nxt = neg_r ? -qv : qv;
          out_last_nxt = (op_r == rlre_pkg::OP_CENTROID) || (j_r == 4'(rlre_pkg::MAX_RUN - 1))
                         || (KW'(j_r) + 1'b1 == KW'(na));
          out_valid_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          dcnt_nxt = dcnt_r + 1'b1;
          if (trial >= {1'b0, den_r}) begin
            rem_nxt = DENW'(trial - {1'b0, den_r});
            dq_nxt = dq_shift | rlre_pkg::DVW'(1);
          end else begin
            rem_nxt = DENW'(trial);
            dq_nxt = dq_shift;
          end
        end
      end
      S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          if (op_r == rlre_pkg::OP_ASYMPTOTE && !out_last_r) begin
            j_nxt = j_r + 1'b1;
            num_nxt = num_r + (rlre_pkg::DVW'(rlre_pkg::PI_Q32) << 1);
            state_nxt = S_ASYM;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pole_cnt_r <= '0;
      zero_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pole_cnt_r <= pole_cnt_nxt;
      zero_cnt_r <= zero_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r <= i_nxt;
    ph_r <= ph_nxt;
    op_r <= op_nxt;
    k_r <= k_nxt;
    x_r <= x_nxt;
    ref_re_r <= ref_re_nxt;
    ref_im_r <= ref_im_nxt;
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    z_r <= z_nxt;
    ang_r <= ang_nxt;
    sub_r <= sub_nxt;
    st_r <= st_nxt;
    parity_r <= parity_nxt;
    neg_r <= neg_nxt;
    j_r <= j_nxt;
    dq_r <= dq_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    dcnt_r <= dcnt_nxt;
    out_on_r <= out_on_nxt;
    out_last_r <= out_last_nxt;
    out_value_r <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  `RLRE_ASSERT_NOW(a_no_take_while_pending, out_tvalid, !in_tready, "input taken while result pending")
  `RLRE_ASSERT_NOW(a_count_bound, 1'b1, (pole_cnt_r <= CW'(MAX_ORDER)) && (zero_cnt_r <= CW'(MAX_ORDER)), "table count beyond depth")
  `RLRE_ASSERT_NEXT(a_result_drops, out_tvalid && out_tready, !out_tvalid, "result repeated after transfer")
  `RLRE_ASSERT_NEXT(a_clear_counts, in_tvalid && in_tready && in_tuser == rlre_pkg::OP_CLEAR, pole_cnt_r == '0 && zero_cnt_r == '0, "clear left entries")

endmodule
